// File: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared constants and types for the triangle unit normal block
// Output format, pipeline step counts and the per-item side-band record.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int PORT_W          = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int OUT_FRAC        = 16;
  localparam int OUT_W           = OUT_FRAC + 2;
  localparam int EPS_RECIP       = 100000;

  // Quotient n^2 * 2^(2*OUT_FRAC+2) / S has this many bits.
  localparam int DIV_STEPS  = 2 * (OUT_FRAC + 1) + 1;
  localparam int ROOT_STEPS = OUT_FRAC + 2;
  localparam int SCALE_LAT  = DIV_STEPS + ROOT_STEPS;

  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][OUT_FRAC:0] raw;
    logic                   degen;
  } side_t;

endpackage

// File: rtl/core/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of a triangle
// Cross product of the edges b - a and c - a, exact squared length, and
// division of each component by the length into signed Q1.16, or the raw components when degenerate.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Handshake
//  input     ax ay az bx by_coord bz cx cy cz          start && !busy
//  result    norm_x norm_y norm_z degenerate           done, one cycle
//
//  One triangle is taken every cycle; busy is always low.
//  Results come out in order after the edge, product, cross-product, square and
//  length stages, the 35-step divider and the 18-step square root of each component.
//  Reset clears only the valid bits; the receiver cannot stall.
module triangle_unit_normal #(
  parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tun_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tun_pkg::PORT_W-1:0]   ax,
  input  logic [tun_pkg::PORT_W-1:0]   ay,
  input  logic [tun_pkg::PORT_W-1:0]   az,
  input  logic [tun_pkg::PORT_W-1:0]   bx,
  input  logic [tun_pkg::PORT_W-1:0]   by_coord,
  input  logic [tun_pkg::PORT_W-1:0]   bz,
  input  logic [tun_pkg::PORT_W-1:0]   cx,
  input  logic [tun_pkg::PORT_W-1:0]   cy,
  input  logic [tun_pkg::PORT_W-1:0]   cz,
  output logic                         done,
  output logic [tun_pkg::OUT_W-1:0]    norm_x,
  output logic [tun_pkg::OUT_W-1:0]    norm_y,
  output logic [tun_pkg::OUT_W-1:0]    norm_z,
  output logic                         degenerate
);
  import tun_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int UW  = CW + 1;
  localparam int PW  = 2 * UW;
  localparam int NW  = PW + 1;
  localparam int H   = UW;
  localparam int MW  = 2 * H;
  localparam int SW  = 2 * MW + 2;
  localparam int EW  = (SW > 128) ? SW : 128;
  localparam int RS  = 2 * FRAC_BITS - OUT_FRAC;
  localparam int RSR = (RS > 0) ? RS : 1;
  localparam int RSL = (RS > 0) ? 0 : -RS;
  localparam int RW  = MW + OUT_FRAC + 2;
  localparam logic [63:0]  EPS = (64'd1 << (2 * FRAC_BITS)) / 64'(EPS_RECIP);
  localparam logic [127:0] E2  = 128'(EPS) * 128'(EPS);

  function automatic logic [OUT_FRAC:0] raw_conv(input logic [MW-1:0] m);
    logic [RW-1:0] wide;
    if (RS > 0) begin
      wide = (RW'(m) + (RW'(1) << (RSR - 1))) >> RSR;
    end else begin
      wide = RW'(m) << RSL;
    end
    if (wide > (RW'(1) << OUT_FRAC)) begin
      return (OUT_FRAC + 1)'(1) << OUT_FRAC;
    end
    return wide[OUT_FRAC:0];
  endfunction

  function automatic logic [OUT_W-1:0] apply_sign(input logic neg,
                                                  input logic [OUT_FRAC:0] mag);
    return neg ? OUT_W'(0) - OUT_W'(mag) : OUT_W'(mag);
  endfunction

  // Stage 1: edge vectors.
  logic signed [UW-1:0] ux, uy, uz, vx, vy, vz;
  // Stage 2: the six products.
  logic signed [PW-1:0] p0, r0, p1, r1, p2, r2;
  // Stage 3: cross product as sign and magnitude.
  logic [2:0]    neg3;
  logic [MW-1:0] mag3 [3];
  // Stage 4: partial squares and the degenerate-path value.
  logic [2:0]           neg4;
  logic [2*H-1:0]       hh4 [3];
  logic [2*H-1:0]       hl4 [3];
  logic [2*H-1:0]       ll4 [3];
  logic [2:0][OUT_FRAC:0] raw4;
  // Stage 5: squares.
  logic [2:0]           neg5;
  logic [2*MW-1:0]      sq5 [3];
  logic [2:0][OUT_FRAC:0] raw5;
  // Stage 6: squared length and degenerate test.
  logic [2*MW-1:0] sq6 [3];
  logic [SW-1:0]   len2;
  side_t           side [0:SCALE_LAT];
  logic [OUT_FRAC:0] qv [3];

  localparam int VLEN = 6 + SCALE_LAT;
  logic [VLEN-1:0] vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[VLEN-2:0], start};
      done <= vld[VLEN-1];
    end
  end

  always_ff @(posedge clk) begin
    ux <= UW'($signed(bx[CW-1:0])) - UW'($signed(ax[CW-1:0]));
    uy <= UW'($signed(by_coord[CW-1:0])) - UW'($signed(ay[CW-1:0]));
    uz <= UW'($signed(bz[CW-1:0])) - UW'($signed(az[CW-1:0]));
    vx <= UW'($signed(cx[CW-1:0])) - UW'($signed(ax[CW-1:0]));
    vy <= UW'($signed(cy[CW-1:0])) - UW'($signed(ay[CW-1:0]));
    vz <= UW'($signed(cz[CW-1:0])) - UW'($signed(az[CW-1:0]));

    p0 <= uy * vz;
    r0 <= uz * vy;
    p1 <= uz * vx;
    r1 <= ux * vz;
    p2 <= ux * vy;
    r2 <= uy * vx;
  end

  logic signed [NW-1:0] nc [3];
  assign nc[0] = NW'(p0) - NW'(r0);
  assign nc[1] = NW'(p1) - NW'(r1);
  assign nc[2] = NW'(p2) - NW'(r2);

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic [H-1:0] hi, lo;
    assign hi = mag3[i][MW-1:H];
    assign lo = mag3[i][H-1:0];

    always_ff @(posedge clk) begin
      neg3[i] <= nc[i][NW-1];
      mag3[i] <= MW'(nc[i][NW-1] ? -nc[i] : nc[i]);

      neg4[i] <= neg3[i];
      hh4[i]  <= hi * hi;
      hl4[i]  <= hi * lo;
      ll4[i]  <= lo * lo;
      raw4[i] <= raw_conv(mag3[i]);

      neg5[i] <= neg4[i];
      raw5[i] <= raw4[i];
      sq5[i]  <= {hh4[i], (2 * H)'(0)} + ((2 * MW)'(hl4[i]) << (H + 1))
                 + (2 * MW)'(ll4[i]);

      sq6[i]  <= sq5[i];
    end

    tun_scale #(
      .MW (MW),
      .SW (SW)
    ) u_scale (
      .clk (clk),
      .n2  (sq6[i]),
      .s   (len2),
      .q   (qv[i])
    );
  end

  logic [SW-1:0] len2_sum;
  assign len2_sum = SW'(sq5[0]) + SW'(sq5[1]) + SW'(sq5[2]);

  always_ff @(posedge clk) begin
    len2          <= len2_sum;
    side[0].neg   <= neg5;
    side[0].raw   <= raw5;
    side[0].degen <= !(EW'(len2_sum) > EW'(E2));
  end

  for (genvar k = 0; k < SCALE_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
    end
  end

  always_ff @(posedge clk) begin
    if (side[SCALE_LAT].degen) begin
      norm_x <= apply_sign(side[SCALE_LAT].neg[0], side[SCALE_LAT].raw[0]);
      norm_y <= apply_sign(side[SCALE_LAT].neg[1], side[SCALE_LAT].raw[1]);
      norm_z <= apply_sign(side[SCALE_LAT].neg[2], side[SCALE_LAT].raw[2]);
    end else begin
      norm_x <= apply_sign(side[SCALE_LAT].neg[0], qv[0]);
      norm_y <= apply_sign(side[SCALE_LAT].neg[1], qv[1]);
      norm_z <= apply_sign(side[SCALE_LAT].neg[2], qv[2]);
    end
    degenerate <= side[SCALE_LAT].degen;
  end

  // Every accepted transaction raises done after the full pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(VLEN + 1) done)
    else $error("result missing after pipeline latency");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(norm_x) <= 65536 && $signed(norm_x) >= -65536 &&
              $signed(norm_y) <= 65536 && $signed(norm_y) >= -65536 &&
              $signed(norm_z) <= 65536 && $signed(norm_z) >= -65536))
    else $error("normal component outside Q1.16 range");

  // A length above epsilon always leaves at least one nonzero component.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (norm_x != '0 || norm_y != '0 || norm_z != '0))
    else $error("scaled normal is all zero");

endmodule

// File: rtl/core/tun_scale.sv
// ----------------------------------------------------------------------------
// tun_scale: one normal component scaled by the inverse length
// Restoring divider for n^2/S followed by a digit-by-digit square root,
// one step per register stage. Gives round-to-nearest |n|/sqrt(S).
// ----------------------------------------------------------------------------
module tun_scale #(
  parameter int MW = 66,
  parameter int SW = 134
) (
  input  logic                     clk,
  input  logic [2*MW-1:0]          n2,
  input  logic [SW-1:0]            s,
  output logic [tun_pkg::OUT_FRAC:0] q
);
  import tun_pkg::*;

  localparam int QW  = DIV_STEPS;
  localparam int RTW = QW + 1;

  logic [SW-1:0]  rem [1:DIV_STEPS];
  logic [SW-1:0]  dvs [1:DIV_STEPS-1];
  logic [QW-1:0]  quo [1:DIV_STEPS];
  logic [QW-1:0]  xr  [1:ROOT_STEPS];
  logic [RTW-1:0] res [1:ROOT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [SW-1:0] rin;
    logic [SW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = SW'(n2);
      assign din = s;
      assign qin = '0;
      // The integer bit: n^2 never exceeds S, so no shift here.
      assign trial = {1'b0, rin};
    end else begin : g_next
      assign rin = rem[k];
      assign din = dvs[k];
      assign qin = quo[k];
      assign trial = {rin, 1'b0};
    end

    assign ge = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? SW'(trial - {1'b0, din}) : SW'(trial);
      quo[k+1] <= {qin[QW-2:0], ge};
    end

    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        dvs[k+1] <= din;
      end
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [RTW-1:0] ONE = RTW'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [QW-1:0]  xin;
    logic [RTW-1:0] rin;
    logic [RTW-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign xin = quo[DIV_STEPS];
      assign rin = '0;
    end else begin : g_next
      assign xin = xr[j];
      assign rin = res[j];
    end

    assign trial = rin + ONE;
    assign ge    = {1'b0, xin} >= trial;

    always_ff @(posedge clk) begin
      xr[j+1]  <= ge ? QW'({1'b0, xin} - trial) : xin;
      res[j+1] <= ge ? (rin >> 1) + ONE : rin >> 1;
    end
  end

  // floor(2x) is the root; rounding x to nearest is (root + 1) / 2.
  assign q = (OUT_FRAC + 1)'((res[ROOT_STEPS] + RTW'(1)) >> 1);

endmodule
